FILE: rtl/tot_pkg.sv
`timescale 1ns / 1ps
package tot_pkg;
  localparam int unsigned CounterBitsDefault = 16;
  localparam logic [19:0] RateReset = 20'd100000;
  localparam int unsigned SecW = 32;
  localparam int unsigned NsecW = 30;
  localparam int unsigned RateW = 20;
  localparam logic [19:0] MicrosPerSec = 20'd1000000;
  localparam logic [19:0] NanosPerMicro = 20'd1000;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_START  = 2'd1,
    REQ_CANCEL = 2'd2,
    REQ_UPTIME = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIV1,
    ST_DIV2,
    ST_OUT
  } state_t;

  // control between the sequencer and the serial divider
  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;
endpackage

FILE: rtl/tot_if.sv
`timescale 1ns / 1ps
interface tot_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] dur_sec;
  logic [29:0] dur_nsec;
  modport source (output valid, req_type, dur_sec, dur_nsec, input ready);
  modport sink (input valid, req_type, dur_sec, dur_nsec, output ready);
endinterface

interface tot_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] time_sec;
  logic [29:0] time_nsec;
  logic        expired;
  logic        armed;
  logic        clipped;
  modport source (output valid, time_sec, time_nsec, expired, armed, clipped, input ready);
  modport sink (input valid, time_sec, time_nsec, expired, armed, clipped, output ready);
endinterface

FILE: rtl/tot_div.sv
`timescale 1ns / 1ps
// restoring divider, one quotient bit per cycle, 64-bit dividend
module tot_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [19:0] divisor,
  output logic        busy,
  output logic [63:0] quot,
  output logic [19:0] rem
);
  logic [63:0] q_r, q_nxt;
  logic [20:0] rem_r, rem_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [19:0] dvs_r, dvs_nxt;
  logic [20:0] sh;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    dvs_nxt = dvs_r;
    sh = {rem_r[19:0], q_r[63]};
    if (start) begin
      q_nxt = dividend;
      rem_nxt = '0;
      cnt_nxt = 7'd64;
      dvs_nxt = divisor;
    end else if (cnt_r != 7'd0) begin
      if (sh >= {1'b0, dvs_r}) begin
        rem_nxt = sh - {1'b0, dvs_r};
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = sh;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign busy = (cnt_r != 7'd0);
  assign quot = q_r;
  assign rem = rem_r[19:0];
endmodule

FILE: rtl/tot_mul.sv
`timescale 1ns / 1ps
// shift-add multiplier, one multiplier bit per cycle, product mod 2^64
module tot_mul (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] mcand,
  input  logic [19:0] mplier,
  output logic        busy,
  output logic [63:0] prod
);
  logic [63:0] acc_r, acc_nxt, mc_r, mc_nxt;
  logic [19:0] mp_r, mp_nxt;
  logic [4:0]  cnt_r, cnt_nxt;

  always_comb begin
    acc_nxt = acc_r;
    mc_nxt = mc_r;
    mp_nxt = mp_r;
    cnt_nxt = cnt_r;
    if (start) begin
      acc_nxt = '0;
      mc_nxt = mcand;
      mp_nxt = mplier;
      cnt_nxt = 5'd20;
    end else if (cnt_r != 5'd0) begin
      if (mp_r[0]) acc_nxt = acc_r + mc_r;
      mc_nxt = {mc_r[62:0], 1'b0};
      mp_nxt = {1'b0, mp_r[19:1]};
      cnt_nxt = cnt_r - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    acc_r <= acc_nxt;
    mc_r <= mc_nxt;
    mp_r <= mp_nxt;
  end

  assign busy = (cnt_r != 5'd0);
  assign prod = acc_r;
endmodule

FILE: rtl/tickless_oneshot_timer_top.sv
`timescale 1ns / 1ps
// channel | dir | payload
// in      | in  | req_type, dur_sec, dur_nsec
// out     | out | time_sec, time_nsec, expired, armed, clipped
// cfg     | in  | cfg_we, cfg_wdata (tick_rate)
// tick: result register and valid loaded at the accepting edge
// start: divide (ns to us) beside a multiply, then a multiply and a divide
// cancel / uptime: multiply and two divides; a cancel with nothing armed skips the divides
// one word in flight at a time
// rst_n synchronous; out stalls hold the result, input waits until it is taken
module tickless_oneshot_timer_top #(
  parameter int unsigned COUNTER_BITS = tot_pkg::CounterBitsDefault
) (
  input  logic         clk,
  input  logic         rst_n,
  tot_in_if.sink       in_ch,
  tot_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic [19:0]  cfg_wdata
);
  localparam logic [COUNTER_BITS-1:0] CMax = '1;

  tot_pkg::state_t st_r, st_nxt;
  logic [19:0] rate_r;
  logic [COUNTER_BITS-1:0] cnt_r, match_r, cnt_nxt;
  logic [31:0] wrap_r;
  logic        arm_r;
  logic [1:0]  req_r;
  logic [31:0] sec_r;
  logic [29:0] nsec_r;
  logic [1:0]  phase_r;
  logic [63:0] acc_r;
  logic        ov_valid_r, ov_exp_r, ov_clip_r, ov_valid_nxt;
  logic [31:0] ov_sec_r;
  logic [29:0] ov_nsec_r;
  logic [19:0] rate_s;
  logic        in_acc, out_free;

  logic        m_start, m_busy, d_start, d_busy;
  logic [63:0] m_a, m_p, d_n, d_q;
  logic [19:0] m_b, d_v, d_r;
  tot_pkg::div_ctl_t dctl;

  assign rate_s = (rate_r == 20'd0) ? 20'd1 : rate_r;
  assign out_free = !ov_valid_r || out_ch.ready;
  assign in_ch.ready = (st_r == tot_pkg::ST_IDLE) && out_free;
  assign in_acc = in_ch.valid && in_ch.ready;
  assign dctl.start = d_start;
  assign dctl.busy = d_busy;
  assign ov_valid_nxt = (in_acc && in_ch.req_type == tot_pkg::REQ_TICK) ||
    (st_r == tot_pkg::ST_OUT && out_free) || (ov_valid_r && !out_ch.ready);

  tot_mul u_mul (.clk, .rst_n, .start(m_start), .mcand(m_a), .mplier(m_b),
    .busy(m_busy), .prod(m_p));
  tot_div u_div (.clk, .rst_n, .start(dctl.start), .dividend(d_n), .divisor(d_v),
    .busy(d_busy), .quot(d_q), .rem(d_r));

  // wide counter state
  logic [63:0] uptime_ticks, diff64;
  logic [COUNTER_BITS-1:0] diff;
  logic [COUNTER_BITS:0] cmp_sum;
  assign diff = match_r - cnt_r;
  assign diff64 = 64'(diff);
  assign uptime_ticks = (64'(wrap_r) << COUNTER_BITS) + 64'(cnt_r);
  assign cnt_nxt = cnt_r + 1'b1;

  // sequencer: phase selects which step of the job runs
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      tot_pkg::ST_IDLE:  if (in_acc && in_ch.req_type != tot_pkg::REQ_TICK)
                           st_nxt = tot_pkg::ST_START;
      tot_pkg::ST_START: st_nxt = tot_pkg::ST_DIV1;
      tot_pkg::ST_DIV1:  if (!m_busy && !d_busy && phase_r == 2'd3) st_nxt = tot_pkg::ST_OUT;
      tot_pkg::ST_DIV2:  st_nxt = tot_pkg::ST_DIV1;
      tot_pkg::ST_OUT:   if (out_free) st_nxt = tot_pkg::ST_IDLE;
      default:           st_nxt = tot_pkg::ST_IDLE;
    endcase
  end

  // unit launches
  always_comb begin
    m_start = 1'b0;
    d_start = 1'b0;
    m_a = '0;
    m_b = rate_s;
    d_n = acc_r;
    d_v = rate_s;
    unique case (st_r)
      tot_pkg::ST_START: begin
        m_start = 1'b1;
        if (req_r == tot_pkg::REQ_START) begin
          m_a = 64'(sec_r);
          // whole microseconds of the interval, beside the seconds product
          d_start = 1'b1;
          d_n = 64'(nsec_r);
          d_v = tot_pkg::NanosPerMicro;
        end else if (req_r == tot_pkg::REQ_CANCEL) begin
          m_a = diff64;
          m_b = tot_pkg::MicrosPerSec;
        end else begin
          m_a = uptime_ticks;
          m_b = tot_pkg::MicrosPerSec;
        end
      end
      tot_pkg::ST_DIV1: begin
        if (!m_busy && !d_busy && phase_r != 2'd3) begin
          unique case (phase_r)
            2'd0: begin
              if (req_r == tot_pkg::REQ_START) begin
                m_start = 1'b1;
                m_a = d_q;
              end else begin
                d_start = 1'b1;
                d_n = m_p;
              end
            end
            2'd1: begin
              d_start = 1'b1;
              d_v = tot_pkg::MicrosPerSec;
              d_n = (req_r == tot_pkg::REQ_START) ? m_p : d_q;
            end
            default: ;
          endcase
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= tot_pkg::ST_IDLE;
      rate_r <= tot_pkg::RateReset;
      cnt_r <= '0;
      wrap_r <= '0;
      match_r <= '0;
      arm_r <= 1'b0;
      ov_valid_r <= 1'b0;
      phase_r <= '0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) rate_r <= cfg_wdata;
      ov_valid_r <= ov_valid_nxt;
      if (in_acc) begin
        req_r <= in_ch.req_type;
        sec_r <= in_ch.dur_sec;
        nsec_r <= in_ch.dur_nsec;
        phase_r <= '0;
        if (in_ch.req_type == tot_pkg::REQ_TICK) begin
          cnt_r <= cnt_nxt;
          if (cnt_nxt == '0) wrap_r <= wrap_r + 32'd1;
          ov_exp_r <= arm_r && (cnt_nxt == match_r);
          if (arm_r && cnt_nxt == match_r) arm_r <= 1'b0;
          ov_sec_r <= '0;
          ov_nsec_r <= '0;
          ov_clip_r <= 1'b0;
        end
      end
      if (st_r == tot_pkg::ST_START && req_r == tot_pkg::REQ_CANCEL &&
          (!arm_r || diff == '0)) begin
        phase_r <= 2'd3;
        acc_r <= '0;
      end
      if (st_r == tot_pkg::ST_DIV1 && !m_busy && !d_busy && phase_r != 2'd3) begin
        if (phase_r == 2'd0 && req_r == tot_pkg::REQ_START) acc_r <= m_p;
        if (phase_r == 2'd1 && req_r == tot_pkg::REQ_START) acc_r <= acc_r;
        phase_r <= phase_r + 2'd1;
        if (phase_r == 2'd2) begin
          if (req_r == tot_pkg::REQ_START) acc_r <= acc_r + d_q;
          else acc_r <= d_q;
          sec_r <= 32'(d_r);
        end
      end
      if (st_r == tot_pkg::ST_OUT && out_free) begin
        ov_exp_r <= 1'b0;
        if (req_r == tot_pkg::REQ_START) begin
          ov_sec_r <= '0;
          ov_nsec_r <= '0;
          ov_clip_r <= (acc_r > 64'(CMax));
          match_r <= cmp_sum[COUNTER_BITS-1:0];
          arm_r <= 1'b1;
        end else begin
          ov_clip_r <= 1'b0;
          if (req_r == tot_pkg::REQ_CANCEL) arm_r <= 1'b0;
          if (req_r == tot_pkg::REQ_CANCEL && (!arm_r || diff == '0)) begin
            ov_sec_r <= '0;
            ov_nsec_r <= '0;
          end else begin
            ov_sec_r <= (acc_r > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : acc_r[31:0];
            ov_nsec_r <= 30'(sec_r[19:0] * 30'd1000);
          end
        end
      end
    end
  end

  assign cmp_sum = {1'b0, cnt_r} +
    ((acc_r > 64'(CMax)) ? {1'b0, CMax} : {1'b0, acc_r[COUNTER_BITS-1:0]});

  assign out_ch.valid = ov_valid_r;
  assign out_ch.time_sec = ov_sec_r;
  assign out_ch.time_nsec = ov_nsec_r;
  assign out_ch.expired = ov_exp_r;
  assign out_ch.armed = arm_r;
  assign out_ch.clipped = ov_clip_r;

`ifndef ASSERT_OFF
  a_busy_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !dctl.busy) else $error("divider busy while idle");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_valid_r && !out_ch.ready) |=> ov_valid_r) else $error("result dropped");
  a_tick_now: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_ch.req_type == tot_pkg::REQ_TICK) |=> ov_valid_r)
    else $error("tick gave no word");
`endif
endmodule

FILE: tb/sv/tb_tickless_oneshot_timer_top.sv
`timescale 1ns / 1ps
module tb_tickless_oneshot_timer_top;
  localparam int unsigned CntBits = 16;
  localparam longint unsigned CntMask = (64'd1 << CntBits) - 1;
  localparam int unsigned StallLimit = 20000;

  typedef struct packed {
    logic [31:0] time_sec;
    logic [29:0] time_nsec;
    logic        expired;
    logic        armed;
    logic        clipped;
  } timer_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [19:0] cfg_wdata = '0;

  tot_in_if in_ch ();
  tot_out_if out_ch ();

  tickless_oneshot_timer_top #(.COUNTER_BITS(CntBits)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predicted timer state
  longint unsigned rate_q;
  longint unsigned count_q;
  logic [31:0] wraps_q;
  longint unsigned match_q;
  logic armed_q;

  timer_reply_t reply_q[$];
  int errors = 0;
  int quiet_cycles = 0;
  bit idle_en = 1'b0;
  bit hold_off = 1'b0;

  function automatic void usec_split(input longint unsigned usec,
                                     output logic [31:0] s, output logic [29:0] ns);
    longint unsigned whole;
    whole = usec / 64'd1000000;
    ns = 30'((usec % 64'd1000000) * 64'd1000);
    s = (whole > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(whole);
  endfunction

  function automatic timer_reply_t timer_predict(input tot_pkg::req_t req,
                                                 input logic [31:0] dsec,
                                                 input logic [29:0] dnsec);
    timer_reply_t r;
    longint unsigned rate, ticks, diff, usec;
    r = '0;
    rate = (rate_q == 0) ? 64'd1 : rate_q;
    case (req)
      tot_pkg::REQ_TICK: begin
        count_q = (count_q + 64'd1) & CntMask;
        if (count_q == 0) wraps_q = wraps_q + 32'd1;
        if (armed_q && count_q == match_q) begin
          armed_q = 1'b0;
          r.expired = 1'b1;
        end
      end
      tot_pkg::REQ_START: begin
        ticks = 64'(dsec) * rate + ((64'(dnsec) / 1000) * rate) / 64'd1000000;
        if (ticks > CntMask) begin
          ticks = CntMask;
          r.clipped = 1'b1;
        end
        match_q = (count_q + ticks) & CntMask;
        armed_q = 1'b1;
      end
      tot_pkg::REQ_CANCEL: begin
        if (armed_q) begin
          diff = (match_q - count_q) & CntMask;
          armed_q = 1'b0;
          if (diff != 0) usec_split((diff * 64'd1000000) / rate, r.time_sec, r.time_nsec);
        end
      end
      default: begin
        ticks = (64'(wraps_q) << CntBits) + count_q;
        usec = (ticks * 64'd1000000) / rate;
        usec_split(usec, r.time_sec, r.time_nsec);
      end
    endcase
    r.armed = armed_q;
    return r;
  endfunction

  // valid stays up after a word until the next falling edge
  task automatic send_word(input tot_pkg::req_t req, input logic [31:0] dsec,
                           input logic [29:0] dnsec);
    @(negedge clk);
    while (idle_en && $urandom_range(99) < 23) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.req_type <= req;
    in_ch.dur_sec <= dsec;
    in_ch.dur_nsec <= dnsec;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    reply_q.push_back(timer_predict(req, dsec, dnsec));
  endtask

  task automatic pause_input();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  task automatic drain_replies();
    pause_input();
    while (reply_q.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
  endtask

  task automatic write_rate(input logic [19:0] value);
    drain_replies();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    rate_q = 64'(value);
  endtask

  task automatic send_start_random();
    logic [31:0] s;
    case ($urandom_range(3))
      0: s = 32'd0;
      1: s = 32'($urandom_range(3));
      2: s = 32'($urandom_range(100));
      default: s = $urandom;
    endcase
    send_word(tot_pkg::REQ_START, s,
              ($urandom_range(9) == 0) ? 30'($urandom) : 30'($urandom_range(999999999)));
  endtask

  task automatic send_random_word();
    int pick;
    pick = $urandom_range(99);
    if (pick < 55) send_word(tot_pkg::REQ_TICK, $urandom, 30'($urandom));
    else if (pick < 75) send_start_random();
    else if (pick < 88) send_word(tot_pkg::REQ_CANCEL, $urandom, 30'($urandom));
    else send_word(tot_pkg::REQ_UPTIME, $urandom, 30'($urandom));
  endtask

  task automatic test_directed();
    send_word(tot_pkg::REQ_UPTIME, 32'd0, 30'd0);
    send_word(tot_pkg::REQ_CANCEL, 32'd0, 30'd0);
    send_word(tot_pkg::REQ_START, 32'd0, 30'd0);
    send_word(tot_pkg::REQ_CANCEL, 32'd0, 30'd0);
    send_word(tot_pkg::REQ_START, 32'd0, 30'd20000);
    send_word(tot_pkg::REQ_TICK, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
    send_word(tot_pkg::REQ_TICK, 32'd0, 30'd0);
    send_word(tot_pkg::REQ_START, 32'hFFFF_FFFF, 30'd999999999);
    send_word(tot_pkg::REQ_CANCEL, 32'd0, 30'd0);
    send_word(tot_pkg::REQ_START, 32'd0, 30'h3FFF_FFFF);
    send_word(tot_pkg::REQ_START, 32'd0, 30'd999999999);
    send_word(tot_pkg::REQ_UPTIME, 32'hFFFF_FFFF, 30'h3FFF_FFFF);
    send_word(tot_pkg::REQ_CANCEL, 32'd0, 30'd0);
  endtask

  // short intervals with a slow tick rate, clipping and a zero rate
  task automatic test_expiry();
    write_rate(20'd1);
    send_word(tot_pkg::REQ_START, 32'd2, 30'd0);
    repeat (3) send_word(tot_pkg::REQ_TICK, 32'd0, 30'd0);
    send_word(tot_pkg::REQ_UPTIME, 32'd0, 30'd0);
    send_word(tot_pkg::REQ_START, 32'd70000, 30'd0);
    send_word(tot_pkg::REQ_CANCEL, 32'd0, 30'd0);
    // zero ticks arms a full wrap ahead
    send_word(tot_pkg::REQ_START, 32'd0, 30'd0);
    repeat (2) send_word(tot_pkg::REQ_TICK, 32'd0, 30'd0);
    send_word(tot_pkg::REQ_CANCEL, 32'd0, 30'd0);
    write_rate(20'd0);
    send_word(tot_pkg::REQ_UPTIME, 32'd0, 30'd0);
    send_word(tot_pkg::REQ_START, 32'd1, 30'd0);
    send_word(tot_pkg::REQ_CANCEL, 32'd0, 30'd0);
  endtask

  task automatic test_back_pressure();
    write_rate(20'd1000000);
    hold_off = 1'b1;
    for (int i = 0; i < 30; i++) send_random_word();
  endtask

  task automatic test_random();
    logic [19:0] rates[5] = '{20'd1, 20'd1000, 20'd100000, 20'd1000000, 20'hFFFFF};
    foreach (rates[k]) begin
      write_rate(rates[k]);
      idle_en = (k != 2);
      for (int i = 0; i < 200; i++) begin
        // pause once halfway until the block has drained
        if (i == 100) begin
          pause_input();
          while (reply_q.size() != 0) @(negedge clk);
        end
        send_random_word();
      end
    end
    idle_en = 1'b1;
  endtask

  // result side
  always @(posedge clk) begin
    timer_reply_t got, want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.time_sec, out_ch.time_nsec, out_ch.expired, out_ch.armed,
              out_ch.clipped};
      if (reply_q.size() == 0) begin
        $error("result word with no expectation");
        errors++;
      end else begin
        want = reply_q.pop_front();
        if (got.time_sec !== want.time_sec) begin
          $error("time_sec exp %0d got %0d", want.time_sec, got.time_sec); errors++;
        end
        if (got.time_nsec !== want.time_nsec) begin
          $error("time_nsec exp %0d got %0d", want.time_nsec, got.time_nsec); errors++;
        end
        if (got.expired !== want.expired) begin
          $error("expired exp %0d got %0d", want.expired, got.expired); errors++;
        end
        if (got.armed !== want.armed) begin
          $error("armed exp %0d got %0d", want.armed, got.armed); errors++;
        end
        if (got.clipped !== want.clipped) begin
          $error("clipped exp %0d got %0d", want.clipped, got.clipped); errors++;
        end
      end
    end
  end

  always @(negedge clk) begin
    if (hold_off) begin
      out_ch.ready <= 1'b0;
      repeat (400) @(negedge clk);
      hold_off = 1'b0;
    end else begin
      out_ch.ready <= !(idle_en && $urandom_range(99) < 23);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= StallLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.req_type = tot_pkg::REQ_TICK;
    in_ch.dur_sec = '0;
    in_ch.dur_nsec = '0;
    out_ch.ready = 1'b0;
    rate_q = 64'(tot_pkg::RateReset);
    count_q = 0;
    wraps_q = '0;
    match_q = 0;
    armed_q = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    idle_en = 1'b1;
    test_directed();
    test_expiry();
    test_back_pressure();
    test_random();
    drain_replies();
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

FILE: files.f
rtl/tot_pkg.sv
rtl/tot_if.sv
rtl/tot_div.sv
rtl/tot_mul.sv
rtl/tickless_oneshot_timer_top.sv
tb/sv/tb_tickless_oneshot_timer_top.sv
